>>> hw/rtl/t2bi_pkg.sv
// Package for the two-dimensional bilinear map: payload structs, request codes,
// the front-to-back command struct and sizing constants. No dependencies.
package t2bi_pkg;

  localparam int XPointsMaxDef = 16;
  localparam int YPointsMaxDef = 16;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 5;

  typedef enum logic [2:0] {
    REQ_WR_X   = 3'd0,
    REQ_WR_Y   = 3'd1,
    REQ_WR_CELL = 3'd2,
    REQ_LERP   = 3'd3,
    REQ_RAW    = 3'd4
  } req_e;

  localparam logic [CfgIdxW-1:0] CFG_X_POINTS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_Y_POINTS = 1'b1;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         col_index;
    logic [3:0]         row_index;
    logic signed [31:0] write_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] lookup_value;
    logic               table_empty;
  } out_item_t;

  // Command handed from the front to the back through the queue.
  typedef struct packed {
    logic               raw;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } cmd_t;

endpackage

>>> hw/rtl/t2bi_queue.sv
// Short two-entry queue between the front and the back of the map block.
// Depends on t2bi_pkg for the command struct.
module t2bi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  t2bi_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output t2bi_pkg::cmd_t rd_data
);
  import t2bi_pkg::*;

  cmd_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wptr_r] <= wr_data;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr_r <= ~wptr_r;
      if (rd_valid && rd_ready) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end
endmodule

>>> hw/rtl/t2bi_div.sv
// Radix-2 restoring divider, 64-bit unsigned dividend by 33-bit divisor, one
// quotient bit per cycle. Depends on nothing.
module t2bi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q_r;
  logic [33:0] rem_r;
  logic [32:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [33:0] shifted;
  logic [34:0] diff;

  assign shifted  = {rem_r[32:0], q_r[63]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs_r};
  assign quotient = q_r;
  assign done     = busy_r && (cnt_r == 7'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
      q_r    <= dividend;
      rem_r  <= 34'd0;
      dvs_r  <= divisor;
    end else if (busy_r && cnt_r != 7'd0) begin
      cnt_r <= cnt_r - 7'd1;
      if (!diff[34]) begin
        rem_r <= diff[33:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[62:0], 1'b0};
      end
    end else begin
      busy_r <= 1'b0;
    end
  end
endmodule

>>> hw/rtl/t2bi_back.sv
// Back part of the map block: holds axis and cell memories, runs the two binary
// searches, reads the corner cells and performs up to three lerps on t2bi_div.
// Depends on t2bi_pkg and t2bi_div.
module t2bi_back #(
  parameter int XPointsMax = t2bi_pkg::XPointsMaxDef,
  parameter int YPointsMax = t2bi_pkg::YPointsMaxDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_kind,
  input  logic [3:0]          wr_col,
  input  logic [3:0]          wr_row,
  input  logic signed [31:0]  wr_value,
  input  logic [4:0]          x_points,
  input  logic [4:0]          y_points,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  t2bi_pkg::cmd_t      cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output t2bi_pkg::out_item_t out_item
);
  import t2bi_pkg::*;

  localparam int XW = $clog2(XPointsMax);
  localparam int YW = $clog2(YPointsMax);
  localparam int CW = XW + YW;
  localparam int NXW = $clog2(XPointsMax + 1);
  localparam int NYW = $clog2(YPointsMax + 1);
  localparam int NW = (NXW > NYW) ? NXW : NYW;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SX    = 13'b0000000000010,
    S_SY    = 13'b0000000000100,
    S_AX    = 13'b0000000001000,
    S_AXW   = 13'b0000000010000,
    S_CELL  = 13'b0000000100000,
    S_CELLW = 13'b0000001000000,
    S_PICK  = 13'b0000010000000,
    S_LSET  = 13'b0000100000000,
    S_LDIV  = 13'b0001000000000,
    S_LFIN  = 13'b0010000000000,
    S_OUT   = 13'b0100000000000,
    S_MUL   = 13'b1000000000000
  } state_e;

  logic signed [31:0] xax_r [XPointsMax];
  logic signed [31:0] yax_r [YPointsMax];
  logic signed [31:0] cell_r [2**CW];

  state_e state_r;
  cmd_t   cmd_r;
  logic [NXW-1:0] nx_r;
  logic [NYW-1:0] ny_r;
  logic [NW-1:0]  lo_r, hi_r;          // search bounds, shared by both axes
  logic [XW-1:0]  xi_r;
  logic [YW-1:0]  yi_r;
  logic [CW-1:0]  caddr_r;
  logic signed [31:0] crd_r, ard_r;
  logic signed [31:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [31:0] c00_r, c01_r, c10_r, c11_r;
  logic [1:0]  cidx_r;
  logic        aidx_r;
  logic [1:0]  lstep_r;
  logic signed [31:0] lo_val_r;
  logic signed [31:0] ly0_r, ly1_r, la0_r, la1_r, lq_r;
  logic        lneg_r, lzero_r;
  logic [32:0] mdy_r, moff_r, mdx_r;
  logic [63:0] prod_r;
  logic        dstart_r;
  logic        ddone;
  logic [63:0] dquot;
  out_item_t   res_r;
  out_item_t   out_r;
  logic        ovalid_r;
  logic [XW-1:0] wcol;
  logic [YW-1:0] wrow;

  // Clamped counts.
  logic [NXW-1:0] nx_c;
  logic [NYW-1:0] ny_c;
  assign nx_c = (32'(x_points) > XPointsMax) ? NXW'(XPointsMax) : NXW'(x_points);
  assign ny_c = (32'(y_points) > YPointsMax) ? NYW'(YPointsMax) : NYW'(y_points);

  assign wcol = XW'(wr_col);
  assign wrow = YW'(wr_row);

  // Writes to the stores.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_kind == REQ_WR_X && 32'(wr_col) < XPointsMax) xax_r[wcol] <= wr_value;
      if (wr_kind == REQ_WR_Y && 32'(wr_row) < YPointsMax) yax_r[wrow] <= wr_value;
      if (wr_kind == REQ_WR_CELL && 32'(wr_col) < XPointsMax && 32'(wr_row) < YPointsMax)
        cell_r[{wrow, wcol}] <= wr_value;
    end
  end

  // Registered cell read port.
  always_ff @(posedge clk) begin
    crd_r <= cell_r[caddr_r];
  end

  // Probe of the search: the axis value at the middle index.
  logic [NW-1:0] mid;
  logic signed [31:0] probe;
  assign mid = NW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  always_comb begin
    if (state_r == S_SX) probe = xax_r[mid[XW-1:0]];
    else                 probe = yax_r[mid[YW-1:0]];
  end

  // Axis endpoint read for the intervals.
  always_ff @(posedge clk) begin
    ard_r <= aidx_r ? yax_r[yi_r + YW'(cidx_r[0])] : xax_r[xi_r + XW'(cidx_r[0])];
  end

  // Lerp front: 33-bit differences and signs.
  logic signed [32:0] dx, dy, off;
  logic signed [31:0] lx;
  assign lx  = (lstep_r == 2'd2) ? cmd_r.query_y : ((ny_r == 1) ? cmd_r.query_x :
               (nx_r == 1 ? cmd_r.query_y : cmd_r.query_x));
  assign dx  = 33'(la1_r) - 33'(la0_r);
  assign dy  = 33'(ly1_r) - 33'(ly0_r);
  assign off = 33'(lx) - 33'(la0_r);

  t2bi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r),
    .dividend(prod_r), .divisor(mdx_r), .done(ddone), .quotient(dquot)
  );

  logic signed [31:0] lres;
  assign lres = lzero_r ? ly0_r : (ly0_r + (lneg_r ? -lq_r : lq_r));

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      dstart_r <= (state_r == S_MUL) && !lzero_r;
      ovalid_r <= ((state_r == S_OUT) && (!ovalid_r || out_ready)) ||
                  (ovalid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            nx_r  <= nx_c;
            ny_r  <= ny_c;
            if (nx_c == 0 || ny_c == 0) begin
              res_r   <= '{lookup_value: 32'sd0, table_empty: 1'b1};
              state_r <= S_OUT;
            end else begin
              lo_r <= '0;
              hi_r <= NW'(nx_c) - NW'(1);
              state_r <= S_SX;
            end
          end
        end
        S_SX: begin
          if (nx_r < 2 || cmd_r.query_x <= xax_r[0]) begin
            xi_r <= '0;
          end else if (cmd_r.query_x >= xax_r[XW'(nx_r - NXW'(1))]) begin
            xi_r <= XW'(nx_r - NXW'(2));
          end else if (lo_r + NW'(1) < hi_r) begin
            if (cmd_r.query_x < probe) hi_r <= mid; else lo_r <= mid;
          end else begin
            xi_r <= XW'(lo_r);
          end
          if (nx_r < 2 || cmd_r.query_x <= xax_r[0] ||
              cmd_r.query_x >= xax_r[XW'(nx_r - NXW'(1))] || !(lo_r + NW'(1) < hi_r)) begin
            lo_r <= '0;
            hi_r <= NW'(ny_r) - NW'(1);
            state_r <= S_SY;
          end
        end
        S_SY: begin
          if (ny_r < 2 || cmd_r.query_y <= yax_r[0]) begin
            yi_r <= '0;
          end else if (cmd_r.query_y >= yax_r[YW'(ny_r - NYW'(1))]) begin
            yi_r <= YW'(ny_r - NYW'(2));
          end else if (lo_r + NW'(1) < hi_r) begin
            if (cmd_r.query_y < probe) hi_r <= mid; else lo_r <= mid;
          end else begin
            yi_r <= YW'(lo_r);
          end
          if (ny_r < 2 || cmd_r.query_y <= yax_r[0] ||
              cmd_r.query_y >= yax_r[YW'(ny_r - NYW'(1))] || !(lo_r + NW'(1) < hi_r)) begin
            cidx_r <= 2'd0;
            aidx_r <= 1'b0;
            state_r <= S_AX;
          end
        end
        S_AX: state_r <= S_AXW;
        S_AXW: begin
          // Collect x0, x1, y0, y1 in turn.
          unique case ({aidx_r, cidx_r[0]})
            2'b00: x0_r <= ard_r;
            2'b01: x1_r <= ard_r;
            2'b10: y0_r <= ard_r;
            default: y1_r <= ard_r;
          endcase
          if (aidx_r && cidx_r[0]) begin
            cidx_r  <= 2'd0;
            caddr_r <= {yi_r, xi_r};
            state_r <= S_CELL;
          end else begin
            if (cidx_r[0]) aidx_r <= 1'b1;
            cidx_r  <= {1'b0, ~cidx_r[0]};
            state_r <= S_AX;
          end
        end
        S_CELL: state_r <= S_CELLW;
        S_CELLW: begin
          case (cidx_r)
            2'd0: c00_r <= crd_r;
            2'd1: c01_r <= crd_r;
            2'd2: c10_r <= crd_r;
            default: c11_r <= crd_r;
          endcase
          if (cidx_r == 2'd3 || cmd_r.raw || (nx_r == 1 && ny_r == 1)) begin
            state_r <= S_PICK;
          end else begin
            cidx_r  <= cidx_r + 2'd1;
            caddr_r <= {yi_r + YW'(cidx_r[1] ^ cidx_r[0] ? 1 : (cidx_r == 2'd2 ? 1 : 0)),
                        xi_r + XW'(cidx_r == 2'd0 || cidx_r == 2'd2 ? 1 : 0)};
            state_r <= S_CELL;
          end
        end
        S_PICK: begin
          if (cmd_r.raw || (nx_r == 1 && ny_r == 1)) begin
            res_r   <= '{lookup_value: c00_r, table_empty: 1'b0};
            state_r <= S_OUT;
          end else begin
            if (nx_r == 1) begin
              la0_r <= y0_r; la1_r <= y1_r; ly0_r <= c00_r; ly1_r <= c10_r;
              lstep_r <= 2'd2;
            end else if (ny_r == 1) begin
              la0_r <= x0_r; la1_r <= x1_r; ly0_r <= c00_r; ly1_r <= c01_r;
              lstep_r <= 2'd3;
            end else begin
              la0_r <= x0_r; la1_r <= x1_r; ly0_r <= c00_r; ly1_r <= c01_r;
              lstep_r <= 2'd0;
            end
            state_r <= S_LSET;
          end
        end
        S_LSET: begin
          mdx_r  <= dx[32] ? 33'(-dx) : 33'(dx);
          mdy_r  <= dy[32] ? 33'(-dy) : 33'(dy);
          moff_r <= off[32] ? 33'(-off) : 33'(off);
          lneg_r <= ((dy[32] != off[32]) != dx[32]) && dy != 0 && off != 0;
          lzero_r <= (dx == 0);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r   <= 64'(mdy_r) * 64'(moff_r);
          state_r  <= lzero_r ? S_LFIN : S_LDIV;
        end
        S_LDIV: begin
          if (ddone) begin
            lq_r    <= dquot[31:0];
            state_r <= S_LFIN;
          end
        end
        S_LFIN: begin
          case (lstep_r)
            2'd0: begin
              lo_val_r <= lres;
              ly0_r <= c10_r; ly1_r <= c11_r;
              lstep_r <= 2'd1;
              state_r <= S_LSET;
            end
            2'd1: begin
              la0_r <= y0_r; la1_r <= y1_r; ly0_r <= lo_val_r; ly1_r <= lres;
              lstep_r <= 2'd2;
              state_r <= S_LSET;
            end
            default: begin
              res_r   <= '{lookup_value: lres, table_empty: 1'b0};
              state_r <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          // The finished result moves to the output register once it is free.
          if (!ovalid_r || out_ready) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/t2bi_front.sv
// Front part of the map block: accepts requests, applies store writes at once
// and queues lookups. Depends on t2bi_pkg.
module t2bi_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  t2bi_pkg::in_item_t in_item,
  input  logic               back_busy,
  output logic               wr_en,
  output logic               q_valid,
  input  logic               q_ready,
  output t2bi_pkg::cmd_t     q_data
);
  import t2bi_pkg::*;

  logic is_lookup;
  logic unused_clk;

  assign is_lookup = (in_item.req_type == REQ_LERP) || (in_item.req_type == REQ_RAW);
  // Writes wait until no lookup is queued or running so a lookup never sees a
  // later write.
  assign in_ready  = is_lookup ? q_ready : !back_busy;
  assign wr_en     = in_valid && in_ready && !is_lookup;
  assign q_valid   = in_valid && is_lookup && in_ready;
  assign q_data    = '{raw: (in_item.req_type == REQ_RAW),
                       query_x: in_item.query_x, query_y: in_item.query_y};

  // The front holds no state of its own.
  assign unused_clk = clk ^ rst_n;
endmodule

>>> hw/rtl/table_2d_bilinear_interpolator.sv
// Top level of the two-dimensional bilinear map block.
// Depends on t2bi_pkg, t2bi_front, t2bi_queue and t2bi_back.
//
// Usage: the input channel (in_valid/in_ready/in_item) carries one request per
// handshake. Requests of type write X point, write Y point and write cell
// update the stores and give no result. Interpolated and raw lookups give
// exactly one result on the output channel (out_valid/out_ready/out_item).
// The configuration port sets x_points (index 0) and y_points (index 1);
// the user must write it only while the block is idle; the block does not enforce this.
//
// Operation: a lookup walks two binary searches, the axis reads, the cell
// reads and then up to three lerps, each around a 64-step radix-2 division
// on the shared divider. Raw lookups skip the lerps, and empty maps skip the
// searches, reads and lerps. Writes are applied at their handshake. Lookups
// are carried out one at a time: the back takes a new lookup only once the
// last result has moved to the output register.
//
// Reset (rst_n low, synchronous) clears the counts and the queue; the stores
// keep no reset value. A stalled receiver holds the result in the output
// register while the front keeps taking lookups into the two-entry queue;
// writes wait until no lookup is queued or running.
module table_2d_bilinear_interpolator #(
  parameter int XPointsMax = t2bi_pkg::XPointsMaxDef,
  parameter int YPointsMax = t2bi_pkg::YPointsMaxDef
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  t2bi_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output t2bi_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [t2bi_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [t2bi_pkg::CfgDataW-1:0]       cfg_data
);
  import t2bi_pkg::*;

  logic [4:0] x_points_r, y_points_r;
  logic       wr_en, q_wv, q_wr, q_rv, q_rr;
  logic       back_busy;
  cmd_t       q_wd, q_rd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_points_r <= 5'd0;
      y_points_r <= 5'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_X_POINTS) x_points_r <= cfg_data;
      if (cfg_index == CFG_Y_POINTS) y_points_r <= cfg_data;
    end
  end

  // A lookup is pending while one waits in the queue or the back is working.
  assign back_busy = q_rv || !q_rr;

  t2bi_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .back_busy(back_busy), .wr_en(wr_en),
    .q_valid(q_wv), .q_ready(q_wr), .q_data(q_wd)
  );

  t2bi_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(q_wv), .wr_ready(q_wr), .wr_data(q_wd),
    .rd_valid(q_rv), .rd_ready(q_rr), .rd_data(q_rd)
  );

  t2bi_back #(.XPointsMax(XPointsMax), .YPointsMax(YPointsMax)) u_back (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_kind(in_item.req_type),
    .wr_col(in_item.col_index), .wr_row(in_item.row_index),
    .wr_value(in_item.write_value), .x_points(x_points_r), .y_points(y_points_r),
    .cmd_valid(q_rv), .cmd_ready(q_rr), .cmd(q_rd),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the two-dimensional bilinear map block.
// Depends on t2bi_pkg and table_2d_bilinear_interpolator; needs nothing else.
// A scoreboard class predicts every lookup and checks the results in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import t2bi_pkg::*;

  // Request codes that the block must ignore.
  localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [2:0] REQ_BAD_LAST  = 3'd7;
  localparam int         AXIS_MAX      = 16;
  localparam int         DRAIN_CYCLES  = 400;

  // Map predictor plus the ordered store of expected lookup results.
  class map_scoreboard;
    int          x_count;
    int          y_count;
    int          x_axis[AXIS_MAX];
    int          y_axis[AXIS_MAX];
    int          cells[AXIS_MAX][AXIS_MAX];
    out_item_t   expected_lookups[$];
    int          errors;

    function void set_count(logic idx, int value);
      if (idx == CFG_X_POINTS) x_count = value;
      else y_count = value;
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
    endtask

    function int span_of(int axis[AXIS_MAX], int n, int v);
      int lo;
      int hi;
      int mid;
      if (n < 2) return 0;
      if (v <= axis[0]) return 0;
      if (v >= axis[n-1]) return n - 2;
      lo = 0;
      hi = n - 1;
      while (lo + 1 < hi) begin
        mid = (lo + hi) / 2;
        if (v < axis[mid]) hi = mid;
        else lo = mid;
      end
      return lo;
    endfunction

    function logic [63:0] magnitude(longint d);
      return (d < 0) ? 64'(-d) : 64'(d);
    endfunction

    // Linear blend with differences at 33 bits and a quotient truncated
    // toward zero; the sum wraps to 32 bits.
    function int blend(int x, int x0, int x1, int y0, int y1);
      longint      dx;
      longint      dy;
      longint      off;
      logic [63:0] quot;
      logic [31:0] qw;
      logic [31:0] sum;
      bit          neg;
      dx  = longint'(x1) - longint'(x0);
      dy  = longint'(y1) - longint'(y0);
      off = longint'(x) - longint'(x0);
      if (dx == 0) return y0;
      quot = (magnitude(dy) * magnitude(off)) / magnitude(dx);
      neg  = ((dy < 0) != (off < 0)) != (dx < 0);
      if (dy == 0 || off == 0) neg = 0;
      qw = quot[31:0];
      if (neg) qw = -qw;
      sum = 32'(y0) + qw;
      return signed'(sum);
    endfunction

    // Notes one accepted request and queues the lookup result it causes.
    function void note_request(in_item_t it);
      int        nx;
      int        ny;
      int        xi;
      int        yi;
      int        lo_row;
      int        hi_row;
      out_item_t res;
      nx = (x_count > AXIS_MAX) ? AXIS_MAX : x_count;
      ny = (y_count > AXIS_MAX) ? AXIS_MAX : y_count;
      case (it.req_type)
        REQ_WR_X:    x_axis[it.col_index] = it.write_value;
        REQ_WR_Y:    y_axis[it.row_index] = it.write_value;
        REQ_WR_CELL: cells[it.row_index][it.col_index] = it.write_value;
        REQ_LERP, REQ_RAW: begin
          res.table_empty  = 1'b0;
          res.lookup_value = '0;
          if (nx == 0 || ny == 0) begin
            res.table_empty = 1'b1;
          end else begin
            xi = span_of(x_axis, nx, it.query_x);
            yi = span_of(y_axis, ny, it.query_y);
            if (it.req_type == REQ_RAW) begin
              res.lookup_value = cells[yi][xi];
            end else if (nx == 1 && ny == 1) begin
              res.lookup_value = cells[0][0];
            end else if (nx == 1) begin
              res.lookup_value = blend(it.query_y, y_axis[yi], y_axis[yi+1],
                                       cells[yi][0], cells[yi+1][0]);
            end else if (ny == 1) begin
              res.lookup_value = blend(it.query_x, x_axis[xi], x_axis[xi+1],
                                       cells[0][xi], cells[0][xi+1]);
            end else begin
              lo_row = blend(it.query_x, x_axis[xi], x_axis[xi+1],
                             cells[yi][xi], cells[yi][xi+1]);
              hi_row = blend(it.query_x, x_axis[xi], x_axis[xi+1],
                             cells[yi+1][xi], cells[yi+1][xi+1]);
              res.lookup_value = blend(it.query_y, y_axis[yi], y_axis[yi+1],
                                       lo_row, hi_row);
            end
          end
          expected_lookups.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task check_result(out_item_t got);
      out_item_t exp;
      if (expected_lookups.size() == 0) begin
        report($sformatf("unexpected result value=%0d empty=%0b",
                         got.lookup_value, got.table_empty));
      end else begin
        exp = expected_lookups.pop_front();
        if (got.lookup_value !== exp.lookup_value)
          report($sformatf("lookup_value %0d, expected %0d",
                           got.lookup_value, exp.lookup_value));
        if (got.table_empty !== exp.table_empty)
          report($sformatf("table_empty %0b, expected %0b",
                           got.table_empty, exp.table_empty));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CfgIdxW-1:0]    cfg_index;
  logic [CfgDataW-1:0]   cfg_data;

  map_scoreboard sb;
  // Percent chance per request of a sender gap, and per cycle of a stall.
  int            send_idle_pct;
  int            recv_stall_pct;

  table_2d_bilinear_interpolator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // Hands one request to the block. The scoreboard learns of it at the edge
  // where the handshake completes. Valid only drops when a gap is inserted.
  task send_request(in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task send_write(req_e kind, int col, int row, int value);
    in_item_t it;
    it             = '0;
    it.req_type    = kind;
    it.col_index   = 4'(col);
    it.row_index   = 4'(row);
    it.write_value = value;
    it.query_x     = $urandom;
    it.query_y     = $urandom;
    send_request(it);
  endtask

  task send_lookup(req_e kind, int qx, int qy);
    in_item_t it;
    it             = '0;
    it.req_type    = kind;
    it.col_index   = 4'($urandom);
    it.row_index   = 4'($urandom);
    it.write_value = $urandom;
    it.query_x     = qx;
    it.query_y     = qy;
    send_request(it);
  endtask

  // Waits until every lookup has come back, then lets trailing writes finish
  // so the counts can be changed while the block is idle.
  task drain_block();
    in_valid <= 1'b0;
    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_counts(int nx, int ny);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_POINTS;
    cfg_data  <= CfgDataW'(nx);
    @(posedge clk);
    sb.set_count(CFG_X_POINTS, nx);
    cfg_index <= CFG_Y_POINTS;
    cfg_data  <= CfgDataW'(ny);
    @(posedge clk);
    sb.set_count(CFG_Y_POINTS, ny);
    cfg_we <= 1'b0;
  endtask

  function int random_value(bit wide);
    return wide ? int'($urandom) : $urandom_range(0, 400) - 200;
  endfunction

  // Loads a sorted axis of random spread; narrow spreads give repeated
  // breakpoints and so zero-width intervals.
  task load_axis(bit is_x);
    int pts[$];
    bit wide;
    wide = $urandom_range(0, 2) == 0;
    pts = {};
    repeat (AXIS_MAX) pts.push_back(random_value(wide));
    pts.sort();
    for (int i = 0; i < AXIS_MAX; i++)
      send_write(is_x ? REQ_WR_X : REQ_WR_Y, i, i, pts[i]);
  endtask

  // Queries mostly land around the loaded breakpoints, including just
  // outside both ends, some exactly on a breakpoint, the rest anywhere.
  function int pick_query(bit is_x, int n);
    int a0;
    int a1;
    int lim;
    lim = (n < 1) ? 1 : ((n > AXIS_MAX) ? AXIS_MAX : n);
    a0 = is_x ? sb.x_axis[0] : sb.y_axis[0];
    a1 = is_x ? sb.x_axis[lim-1] : sb.y_axis[lim-1];
    case ($urandom_range(0, 9))
      0, 1: return int'($urandom);
      2: return is_x ? sb.x_axis[$urandom_range(0, lim-1)]
                     : sb.y_axis[$urandom_range(0, lim-1)];
      default: begin
        if (a1 - a0 > 1000 || a1 < a0) return a0 + int'($urandom % 1024) - 100;
        return $urandom_range(0, (a1 - a0) + 200) + a0 - 100;
      end
    endcase
  endfunction

  // One phase of random traffic under the given counts.
  task random_phase(int nx, int ny, int items);
    int pick;
    if ($urandom_range(0, 3) != 0) begin
      load_axis(1'b1);
      load_axis(1'b0);
    end
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        send_lookup(REQ_LERP, pick_query(1'b1, nx), pick_query(1'b0, ny));
      else if (pick < 70)
        send_lookup(REQ_RAW, pick_query(1'b1, nx), pick_query(1'b0, ny));
      else if (pick < 88)
        send_write(REQ_WR_CELL, $urandom, $urandom,
                   random_value(1'($urandom_range(0, 1))));
      else if (pick < 91)
        send_write(REQ_WR_X, $urandom, $urandom, $urandom);
      else if (pick < 94)
        send_write(REQ_WR_Y, $urandom, $urandom, $urandom);
      else
        send_write(req_e'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)),
                   $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int nx;
    int ny;
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty map: lookups must report an empty table while the counts are zero.
    send_lookup(REQ_LERP, 32'sh7fffffff, 32'sh80000000);
    send_lookup(REQ_RAW, 0, 0);

    // Fill every store entry once so no lookup can read an unwritten one.
    for (int r = 0; r < AXIS_MAX; r++)
      for (int c = 0; c < AXIS_MAX; c++)
        send_write(REQ_WR_CELL, c, r, random_value(1'($urandom_range(0, 1))));
    load_axis(1'b1);
    load_axis(1'b0);

    // One axis empty while the other is full.
    drain_block();
    write_counts(0, 16);
    send_lookup(REQ_LERP, 5, 5);

    // A single cell returns the corner cell for an interpolated lookup.
    drain_block();
    write_counts(1, 1);
    send_write(REQ_WR_CELL, 0, 0, 32'sh80000000);
    send_lookup(REQ_LERP, 32'sh80000000, 32'sh7fffffff);
    send_lookup(REQ_RAW, 12, -12);

    // Counts above the axis size act as the full axis; corner extremes and
    // queries beyond both ends exercise extrapolation and wrapping.
    drain_block();
    write_counts(31, 31);
    send_write(REQ_WR_CELL, 15, 15, 32'sh7fffffff);
    send_write(REQ_WR_CELL, 14, 15, 32'sh80000000);
    send_write(REQ_WR_CELL, 0, 0, 32'sh80000000);
    send_write(REQ_WR_CELL, 1, 0, 32'sh7fffffff);
    send_lookup(REQ_LERP, 32'sh7fffffff, 32'sh7fffffff);
    send_lookup(REQ_LERP, 32'sh80000000, 32'sh80000000);
    send_lookup(REQ_RAW, 32'sh7fffffff, 32'sh80000000);
    send_lookup(REQ_LERP, sb.x_axis[0], sb.y_axis[15]);
    send_lookup(REQ_LERP, sb.x_axis[7], sb.y_axis[8]);
    send_write(req_e'(REQ_BAD_FIRST), 3, 3, 0);
    send_write(req_e'(REQ_BAD_LAST), 15, 15, -1);
    send_lookup(REQ_RAW, sb.x_axis[15], sb.y_axis[0]);

    // Random phases cycle through the four idling modes and many counts.
    for (int ph = 0; ph < 12; ph++) begin
      drain_block();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case (ph)
        0: begin nx = 16; ny = 16; end
        1: begin nx = 1;  ny = 9;  end
        2: begin nx = 7;  ny = 1;  end
        3: begin nx = 2;  ny = 2;  end
        4: begin nx = 0;  ny = 3;  end
        5: begin nx = 31; ny = 16; end
        default: begin nx = $urandom_range(1, 31); ny = $urandom_range(1, 31); end
      endcase
      write_counts(nx, ny);
      random_phase(nx, ny, 60);
    end

    drain_block();
    if (sb.errors == 0) begin
      $display("table_2d_bilinear_interpolator: match");
    end else begin
      $display("table_2d_bilinear_interpolator: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("table_2d_bilinear_interpolator: mismatch");
    $finish;
  end

endmodule
